>>> src/fpfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared constants for the fixed-partition fit allocator: field widths,
// operation codes, placement rules and register indexes.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int OPCODE_W     = 1;
    localparam int BLK_IDX_W    = 5;
    localparam int FIELD_SIZE_W = 16;
    localparam int FIT_MODE_W   = 2;
    localparam int BLK_COUNT_W  = 6;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b1;

    localparam logic [FIT_MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [FIT_MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [FIT_MODE_W-1:0] FIT_WORST = 2'd2;

    localparam logic REG_FIT_MODE    = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

endpackage

`default_nettype wire

>>> src/fixed_partition_fit_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Loads partition sizes into a table and allocates a free partition that
// fits a process by first, best or worst fit, one table entry per cycle.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         i_valid / o_ready         opcode, block_index, sizes
//  result    out        o_valid / i_ready         granted, index, size
//  config    in         psel/penable/pwrite/pready fit_mode, block_count
//
//  A load goes through the load and done states. An allocate reads
//  L = min(block_count, NUM_BLOCKS) table entries in the scan state, then
//  the last and done states; with an undefined rule or L of zero it goes
//  straight to done. A new transaction can be taken in the same cycle
//  as a result appears. Reset clears config, used flags and control state.
//  While a result waits, the next one is finished and held in the sequencer.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator #(
    parameter int NUM_BLOCKS = 32,
    parameter int SIZE_BITS  = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [fpfa_pkg::OPCODE_W-1:0]        i_opcode,
    input  wire logic [fpfa_pkg::BLK_IDX_W-1:0]       i_block_index,
    input  wire logic [fpfa_pkg::FIELD_SIZE_W-1:0]    i_block_size,
    input  wire logic [fpfa_pkg::FIELD_SIZE_W-1:0]    i_process_size,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic                                      o_granted,
    output logic      [fpfa_pkg::BLK_IDX_W-1:0]       o_chosen_index,
    output logic      [fpfa_pkg::FIELD_SIZE_W-1:0]    o_chosen_size,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [fpfa_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [fpfa_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [fpfa_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                      pready
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int IXE_W = (IDX_W > fpfa_pkg::BLK_IDX_W) ? IDX_W : fpfa_pkg::BLK_IDX_W;
    localparam int INR_W = (CNT_W > fpfa_pkg::BLK_IDX_W) ? CNT_W : fpfa_pkg::BLK_IDX_W;
    localparam int LIM_W = (CNT_W > fpfa_pkg::BLK_COUNT_W) ? CNT_W : fpfa_pkg::BLK_COUNT_W;
    localparam int SZE_W = (SIZE_BITS > fpfa_pkg::FIELD_SIZE_W) ? SIZE_BITS
                                                                : fpfa_pkg::FIELD_SIZE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_LAST = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [fpfa_pkg::FIT_MODE_W-1:0]  r_fit_mode;
    logic [fpfa_pkg::BLK_COUNT_W-1:0] r_block_count;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [IDX_W-1:0]      r_addr;
    logic [IDX_W-1:0]      r_last;
    logic                  r_rd_valid;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [NUM_BLOCKS-1:0] r_used;
    logic                  r_is_alloc;
    logic                  r_in_range;
    logic [IDX_W-1:0]      r_load_idx;
    logic [SIZE_BITS-1:0]  r_load_size;
    logic [SIZE_BITS-1:0]  r_psz;
    logic                  r_found;
    logic [IDX_W-1:0]      r_pick;
    logic [SIZE_BITS-1:0]  r_pick_size;

    logic                  in_accept;
    logic                  out_free;
    logic [IXE_W-1:0]      in_idx_ext;
    logic [INR_W-1:0]      in_idx_cmp;
    logic [SZE_W-1:0]      in_bsz_ext;
    logic [SZE_W-1:0]      in_psz_ext;
    logic [LIM_W-1:0]      cnt_ext;
    logic [LIM_W-1:0]      limit;
    logic [LIM_W-1:0]      limit_m1;
    logic [SIZE_BITS-1:0]  ram_rdata;
    logic                  fits;
    logic                  better;
    logic                  take;
    logic [IXE_W-1:0]      pick_ext;
    logic [SZE_W-1:0]      pick_size_ext;

    assign pready    = 1'b1;
    assign o_ready   = (r_state == S_IDLE);
    assign in_accept = i_valid && o_ready;
    assign out_free  = !o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode    <= '0;
            r_block_count <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == fpfa_pkg::REG_FIT_MODE) begin
                r_fit_mode <= pwdata[fpfa_pkg::FIT_MODE_W-1:0];
            end else begin
                r_block_count <= pwdata[fpfa_pkg::BLK_COUNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == fpfa_pkg::REG_BLOCK_COUNT) begin
            prdata = fpfa_pkg::APB_DATA_W'(r_block_count);
        end else begin
            prdata = fpfa_pkg::APB_DATA_W'(r_fit_mode);
        end
    end

    assign in_idx_ext = IXE_W'(i_block_index);
    assign in_idx_cmp = INR_W'(i_block_index);
    assign in_bsz_ext = SZE_W'(i_block_size);
    assign in_psz_ext = SZE_W'(i_process_size);
    assign cnt_ext    = LIM_W'(r_block_count);
    assign limit      = (cnt_ext > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : cnt_ext;
    assign limit_m1   = limit - LIM_W'(1);

    fpfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_LOAD) && r_in_range),
        .i_waddr (r_load_idx),
        .i_wdata (r_load_size),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign fits   = !r_used[r_rd_idx] && (ram_rdata >= r_psz);
    assign better = (r_fit_mode == fpfa_pkg::FIT_BEST) ? (ram_rdata < r_pick_size)
                                                       : (ram_rdata > r_pick_size);
    assign take   = r_rd_valid && fits &&
                    (!r_found || ((r_fit_mode != fpfa_pkg::FIT_FIRST) && better));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_opcode == fpfa_pkg::OP_LOAD) begin
                        n_state = S_LOAD;
                    end else if (r_fit_mode inside {fpfa_pkg::FIT_FIRST, fpfa_pkg::FIT_BEST,
                                                    fpfa_pkg::FIT_WORST} &&
                                 limit != '0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LOAD: n_state = S_DONE;
            S_SCAN: begin
                if (r_addr == r_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_valid <= 1'b0;
            r_used     <= '0;
            r_found    <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= (r_state == S_SCAN);
            if ((r_state == S_DONE) && out_free) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_found <= 1'b0;
                end
                S_LOAD: begin
                    r_found     <= r_in_range;
                    r_pick      <= r_load_idx;
                    r_pick_size <= r_load_size;
                    if (r_in_range) begin
                        r_used[r_load_idx] <= 1'b0;
                    end
                end
                S_SCAN, S_LAST: begin
                    if (take) begin
                        r_found     <= 1'b1;
                        r_pick      <= r_rd_idx;
                        r_pick_size <= ram_rdata;
                    end
                end
                S_DONE: begin
                    if (out_free && r_is_alloc && r_found) begin
                        r_used[r_pick] <= 1'b1;
                    end
                end
                default: begin
                    r_found <= 1'b0;
                end
            endcase
        end
    end

    assign pick_ext      = IXE_W'(r_pick);
    assign pick_size_ext = SZE_W'(r_pick_size);

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (r_state == S_SCAN) begin
            r_addr <= r_addr + IDX_W'(1);
        end
        if (in_accept) begin
            r_is_alloc  <= (i_opcode == fpfa_pkg::OP_ALLOC);
            r_in_range  <= (in_idx_cmp < INR_W'(NUM_BLOCKS));
            r_load_idx  <= in_idx_ext[IDX_W-1:0];
            r_load_size <= in_bsz_ext[SIZE_BITS-1:0];
            r_psz       <= in_psz_ext[SIZE_BITS-1:0];
            r_addr      <= '0;
            r_last      <= limit_m1[IDX_W-1:0];
        end
        if ((r_state == S_DONE) && out_free) begin
            o_granted      <= r_found;
            o_chosen_index <= r_found ? pick_ext[fpfa_pkg::BLK_IDX_W-1:0] : '0;
            o_chosen_size  <= r_found ? pick_size_ext[fpfa_pkg::FIELD_SIZE_W-1:0] : '0;
        end
    end

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_ready
    ) else $error("allocator accepted a transaction while busy");

    a_ungranted_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_granted) |-> (o_chosen_index == '0 && o_chosen_size == '0)
    ) else $error("ungranted result carries a nonzero index or size");

    a_scan_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_last)
    ) else $error("scan address ran past the last entry");

    a_read_in_scan: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_state == S_SCAN || r_state == S_LAST)
    ) else $error("table read data arrived outside the scan");

    a_result_after_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_DONE)
    ) else $error("result appeared without the sequencer finishing");

endmodule

`default_nettype wire

>>> src/fpfa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpfa_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
